// File: src/fskv_pkg.sv
// Shared types, widths and helper functions for the free-surface kinematic velocity core.
// No dependencies; the core, the axis and the checker use this package.
package fskv_pkg;

    localparam int VAL_W          = 32;   // Q16.16 word
    localparam int DIST_W         = 31;   // unsigned Q15.16 spacing
    localparam int FRAC_W         = 16;
    localparam int DIFF_W         = VAL_W + 1;
    localparam int SLOPE_NUM_W    = DIFF_W + FRAC_W;
    localparam int SLOPE_DEN_W    = DIST_W + 1;
    localparam int SLOPE_Q_W      = VAL_W - 1;
    localparam int LIM_NUM_W      = 2 * VAL_W;
    localparam int LIM_DEN_W      = VAL_W + 1;
    localparam int LIM_Q_W        = VAL_W;
    localparam int PROD_W         = 2 * VAL_W;
    localparam int TERM_W         = PROD_W - FRAC_W;
    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [1:0] {
        GM_OFF     = 2'd0,
        GM_UPWIND  = 2'd1,
        GM_CENTRAL = 2'd2,
        GM_LIMITED = 2'd3
    } grad_mode_t;

    // Apply sign and clamp a divider magnitude to a signed Q16.16 slope.
    function automatic logic [VAL_W-1:0] slope_sat(input logic neg, input logic ovf,
                                                   input logic [SLOPE_Q_W-1:0] q);
        logic [VAL_W-1:0] mag;
        begin
            mag = {1'b0, q};
            if (ovf)
                slope_sat = neg ? VAL_MIN : VAL_MAX;
            else
                slope_sat = neg ? (~mag + 1'b1) : mag;
        end
    endfunction

    // Magnitude of a two's complement word, as unsigned.
    function automatic logic [VAL_W-1:0] abs_val(input logic [VAL_W-1:0] x);
        begin
            abs_val = x[VAL_W-1] ? (~x + 1'b1) : x;
        end
    endfunction

endpackage

// File: src/free_surface_kinematic_velocity_core.sv
// Channel | direction | handshake            | words
// in      | into core | in_valid / in_stall   | u_vel .. dy_fwd, one stencil point
// out     | from core | out_valid / out_stall | w_vel
// cfg     | into core | cfg_valid / cfg_ready | gradient_mode
//
// One point enters every cycle while in_stall is low; most of the pipeline lies in the two
// pipelined divider chains (31 slope stages, then 32 limiter stages) in each axis.
// Reset (rst_n low, asynchronous) empties the pipeline and sets gradient_mode to upwind.
// A stalled result holds in the output register; one more lands in a skid register,
// and only while that skid register is full does in_stall rise and the pipeline freeze.
// Depends on fskv_pkg and fskv_axis.
module free_surface_kinematic_velocity_core #(
    parameter int DATA_WIDTH = fskv_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [fskv_pkg::VAL_W-1:0]  u_vel,
    input  logic signed [fskv_pkg::VAL_W-1:0]  v_vel,
    input  logic signed [fskv_pkg::VAL_W-1:0]  eta_rate,
    input  logic signed [fskv_pkg::VAL_W-1:0]  eta_centre,
    input  logic signed [fskv_pkg::VAL_W-1:0]  eta_west,
    input  logic signed [fskv_pkg::VAL_W-1:0]  eta_east,
    input  logic signed [fskv_pkg::VAL_W-1:0]  eta_south,
    input  logic signed [fskv_pkg::VAL_W-1:0]  eta_north,
    input  logic [fskv_pkg::DIST_W-1:0]        dx_back,
    input  logic [fskv_pkg::DIST_W-1:0]        dx_fwd,
    input  logic [fskv_pkg::DIST_W-1:0]        dy_back,
    input  logic [fskv_pkg::DIST_W-1:0]        dy_fwd,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [fskv_pkg::VAL_W-1:0]  w_vel,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         gradient_mode
);
    import fskv_pkg::*;

    localparam int SIDE_W = 2 + VAL_W;
    localparam int SUM_W  = TERM_W + 2;
    localparam int CMP_W  = 66;
    localparam logic signed [CMP_W-1:0] SAT_HI =
        {{(CMP_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [CMP_W-1:0] SAT_LO = ~SAT_HI;

    // ---- configuration: always ready; the user must write it only while idle, the block does not enforce this
    grad_mode_t mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= GM_UPWIND;
        else if (cfg_valid && cfg_ready)
            mode_reg <= grad_mode_t'(gradient_mode);
    end

    // ---- pipeline advances whenever the skid register is free
    logic skid_vld_reg;
    logic pipe_en;

    assign pipe_en  = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    // ---- the two axes; x carries the mode and eta_rate alongside
    logic                     ax_vld;
    logic signed [TERM_W-1:0] ax_term, ay_term;
    logic [SIDE_W-1:0]        ax_side;
    logic [0:0]               ay_side;

    fskv_axis #(
        .SIDE_W(SIDE_W)
    ) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (in_valid),
        .mode     (mode_reg),
        .vel      (u_vel),
        .e_c      (eta_centre),
        .e_m      (eta_west),
        .e_p      (eta_east),
        .d_back   (dx_back),
        .d_fwd    (dx_fwd),
        .side_in  ({mode_reg, eta_rate}),
        .out_valid(ax_vld),
        .term     (ax_term),
        .side_out (ax_side)
    );

    fskv_axis #(
        .SIDE_W(1)
    ) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (in_valid),
        .mode     (mode_reg),
        .vel      (v_vel),
        .e_c      (eta_centre),
        .e_m      (eta_south),
        .e_p      (eta_north),
        .d_back   (dy_back),
        .d_fwd    (dy_fwd),
        .side_in  (1'b0),
        .out_valid(),
        .term     (ay_term),
        .side_out (ay_side)
    );

    logic [1:0]              ax_mode_bits;
    grad_mode_t              ax_mode;
    logic signed [VAL_W-1:0] ax_rate;

    assign {ax_mode_bits, ax_rate} = ax_side;
    assign ax_mode = grad_mode_t'(ax_mode_bits);

    // ---- sum of rate and both terms
    logic                    sm_vld_reg;
    grad_mode_t              sm_mode_reg;
    logic signed [SUM_W-1:0] sm_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_vld_reg <= 1'b0;
        else if (pipe_en)
            sm_vld_reg <= ax_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sm_mode_reg <= ax_mode;
            sm_sum_reg  <= SUM_W'(ax_rate) + SUM_W'(ax_term) + SUM_W'(ay_term)
                           + SUM_W'(ay_side & 1'b0);
        end
    end

    // ---- clamp to the DATA_WIDTH range; mode off forces zero
    logic signed [CMP_W-1:0] sum_ext, sat_val;
    logic                    ps_vld_reg;
    logic [VAL_W-1:0]        ps_w_reg;

    assign sum_ext = CMP_W'(sm_sum_reg);

    always_comb
    begin
        if (sum_ext > SAT_HI)
            sat_val = SAT_HI;
        else if (sum_ext < SAT_LO)
            sat_val = SAT_LO;
        else
            sat_val = sum_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ps_vld_reg <= 1'b0;
        else if (pipe_en)
            ps_vld_reg <= sm_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            ps_w_reg <= (sm_mode_reg == GM_OFF) ? '0 : sat_val[VAL_W-1:0];
    end

    // ---- output register with skid: hold the stalled word, park the next one
    logic             out_vld_reg;
    logic [VAL_W-1:0] out_w_reg, skid_w_reg;
    logic             out_free;

    assign out_free = !out_vld_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg  <= skid_vld_reg || ps_vld_reg;
            skid_vld_reg <= 1'b0;
        end
        else if (ps_vld_reg && pipe_en)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_w_reg <= skid_vld_reg ? skid_w_reg : ps_w_reg;
        if (!out_free && pipe_en)
            skid_w_reg <= ps_w_reg;
    end

    assign out_valid = out_vld_reg;
    assign w_vel     = out_w_reg;

endmodule

// File: src/fskv_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried along.
// Depends on nothing; quotient is valid only when ovf is low.
module fskv_div #(
    parameter int NUM_W  = 49,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic              ovf,
    output logic [SIDE_W-1:0] side_out
);
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              vld_reg  [0:Q_W];
    logic [DEN_W-1:0]  rem_reg  [0:Q_W];
    logic [Q_W-1:0]    low_reg  [0:Q_W];
    logic [Q_W-1:0]    q_reg    [0:Q_W];
    logic [DEN_W-1:0]  den_reg  [0:Q_W];
    logic              ovf_reg  [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];

    logic [HI_W-1:0] num_hi;
    logic            ovf_next;

    // Quotient overflows Q_W bits when the high part already reaches the divisor.
    assign num_hi   = num[NUM_W-1:Q_W];
    assign ovf_next = CMP_W'(num_hi) >= CMP_W'(den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DEN_W'(num_hi);
            low_reg[0]  <= num[Q_W-1:0];
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_step
        logic [DEN_W:0]   rem_shift;
        logic             take;
        logic [DEN_W:0]   rem_sub;
        logic [DEN_W-1:0] rem_next;

        assign rem_shift = {rem_reg[k-1], low_reg[k-1][Q_W-1]};
        assign take      = rem_shift >= {1'b0, den_reg[k-1]};
        assign rem_sub   = rem_shift - {1'b0, den_reg[k-1]};
        assign rem_next  = take ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= {low_reg[k-1][Q_W-2:0], 1'b0};
                q_reg[k]    <= {q_reg[k-1][Q_W-2:0], take};
                den_reg[k]  <= den_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

// File: src/fskv_axis.sv
// One axis of the velocity sum: gradient by mode, then velocity times gradient in Q16.16.
// Depends on fskv_pkg and fskv_div.
module fskv_axis #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  fskv_pkg::grad_mode_t                mode,
    input  logic signed [fskv_pkg::VAL_W-1:0]   vel,
    input  logic signed [fskv_pkg::VAL_W-1:0]   e_c,
    input  logic signed [fskv_pkg::VAL_W-1:0]   e_m,
    input  logic signed [fskv_pkg::VAL_W-1:0]   e_p,
    input  logic [fskv_pkg::DIST_W-1:0]         d_back,
    input  logic [fskv_pkg::DIST_W-1:0]         d_fwd,
    input  logic [SIDE_W-1:0]                   side_in,
    output logic                                out_valid,
    output logic signed [fskv_pkg::TERM_W-1:0]  term,
    output logic [SIDE_W-1:0]                   side_out
);
    import fskv_pkg::*;

    localparam int DA_SIDE_W = SIDE_W + 2 + VAL_W + 2;
    localparam int DB_SIDE_W = SIDE_W + 2 + 2 * VAL_W + 2;

    // ---- front: differences and divisors
    logic signed [DIFF_W-1:0] dif_back, dif_fwd, dif_cen, df_sel;
    logic [SLOPE_DEN_W-1:0]   dn_sel, dn_back, dn_raw;
    logic                     vzero, vpos;

    assign dif_back = DIFF_W'(e_c) - DIFF_W'(e_m);
    assign dif_fwd  = DIFF_W'(e_p) - DIFF_W'(e_c);
    assign dif_cen  = DIFF_W'(e_p) - DIFF_W'(e_m);
    assign vzero    = (vel == '0);
    assign vpos     = !vel[VAL_W-1] && !vzero;

    always_comb
    begin
        case (mode)
            GM_UPWIND:
            begin
                df_sel = vpos ? dif_back : dif_fwd;
                dn_raw = vpos ? {1'b0, d_back} : {1'b0, d_fwd};
            end
            GM_CENTRAL:
            begin
                df_sel = dif_cen;
                dn_raw = {1'b0, d_back} + {1'b0, d_fwd};
            end
            default:
            begin
                df_sel = dif_fwd;
                dn_raw = {1'b0, d_fwd};
            end
        endcase
        // a zero spacing counts as one LSB
        dn_sel  = (dn_raw == '0) ? SLOPE_DEN_W'(1) : dn_raw;
        dn_back = (d_back == '0) ? SLOPE_DEN_W'(1) : {1'b0, d_back};
    end

    logic                   fr_vld_reg;
    grad_mode_t             fr_mode_reg;
    logic [VAL_W-1:0]       fr_vel_reg;
    logic                   fr_vzero_reg;
    logic [SIDE_W-1:0]      fr_side_reg;
    logic                   fr_sf_reg, fr_sb_reg;
    logic [DIFF_W-1:0]      fr_mf_reg, fr_mb_reg;
    logic [SLOPE_DEN_W-1:0] fr_dnf_reg, fr_dnb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_vld_reg <= 1'b0;
        else if (en)
            fr_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fr_mode_reg  <= mode;
            fr_vel_reg   <= vel;
            fr_vzero_reg <= vzero;
            fr_side_reg  <= side_in;
            fr_sf_reg    <= df_sel[DIFF_W-1];
            fr_sb_reg    <= dif_back[DIFF_W-1];
            fr_mf_reg    <= df_sel[DIFF_W-1] ? -df_sel : df_sel;
            fr_mb_reg    <= dif_back[DIFF_W-1] ? -dif_back : dif_back;
            fr_dnf_reg   <= dn_sel;
            fr_dnb_reg   <= dn_back;
        end
    end

    // ---- slope dividers
    logic                   da_vld, da_ovf, db_ovf;
    logic [SLOPE_Q_W-1:0]   da_q, db_q;
    logic [DA_SIDE_W-1:0]   da_side;
    logic [0:0]             db_side;

    fskv_div #(
        .NUM_W (SLOPE_NUM_W),
        .DEN_W (SLOPE_DEN_W),
        .Q_W   (SLOPE_Q_W),
        .SIDE_W(DA_SIDE_W)
    ) u_div_fwd (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (fr_vld_reg),
        .num      ({fr_mf_reg, {FRAC_W{1'b0}}}),
        .den      (fr_dnf_reg),
        .side_in  ({fr_side_reg, fr_mode_reg, fr_vel_reg, fr_vzero_reg, fr_sf_reg}),
        .out_valid(da_vld),
        .quot     (da_q),
        .ovf      (da_ovf),
        .side_out (da_side)
    );

    fskv_div #(
        .NUM_W (SLOPE_NUM_W),
        .DEN_W (SLOPE_DEN_W),
        .Q_W   (SLOPE_Q_W),
        .SIDE_W(1)
    ) u_div_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (fr_vld_reg),
        .num      ({fr_mb_reg, {FRAC_W{1'b0}}}),
        .den      (fr_dnb_reg),
        .side_in  (fr_sb_reg),
        .out_valid(),
        .quot     (db_q),
        .ovf      (db_ovf),
        .side_out (db_side)
    );

    // ---- slope stage
    logic [SIDE_W-1:0] da_s_side;
    logic [1:0]        da_s_mode_bits;
    grad_mode_t        da_s_mode;
    logic [VAL_W-1:0]  da_s_vel, sa, sb;
    logic              da_s_vzero, da_s_sign;

    assign {da_s_side, da_s_mode_bits, da_s_vel, da_s_vzero, da_s_sign} = da_side;
    assign da_s_mode = grad_mode_t'(da_s_mode_bits);
    assign sa = slope_sat(da_s_sign, da_ovf, da_q);
    assign sb = slope_sat(db_side[0], db_ovf, db_q);

    logic              sl_vld_reg, sl_lz_reg, sl_neg_reg;
    grad_mode_t        sl_mode_reg;
    logic [VAL_W-1:0]  sl_vel_reg, sl_g_reg, sl_ma_reg, sl_mb_reg;
    logic [SIDE_W-1:0] sl_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sl_vld_reg <= 1'b0;
        else if (en)
            sl_vld_reg <= da_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl_mode_reg <= da_s_mode;
            sl_vel_reg  <= da_s_vel;
            sl_side_reg <= da_s_side;
            sl_g_reg    <= (da_s_mode == GM_UPWIND && da_s_vzero) ? '0 : sa;
            sl_lz_reg   <= (sa == '0) || (sb == '0) || (sa[VAL_W-1] != sb[VAL_W-1]);
            sl_neg_reg  <= sa[VAL_W-1];
            sl_ma_reg   <= abs_val(sa);
            sl_mb_reg   <= abs_val(sb);
        end
    end

    // ---- limiter product and divisor
    logic              pr_vld_reg, pr_lz_reg, pr_neg_reg;
    grad_mode_t        pr_mode_reg;
    logic [VAL_W-1:0]  pr_vel_reg, pr_g_reg;
    logic [SIDE_W-1:0] pr_side_reg;
    logic [PROD_W-1:0] pr_num_reg, mm;
    logic [LIM_DEN_W-1:0] pr_den_reg;

    assign mm = PROD_W'(sl_ma_reg) * PROD_W'(sl_mb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_vld_reg <= 1'b0;
        else if (en)
            pr_vld_reg <= sl_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_mode_reg <= sl_mode_reg;
            pr_vel_reg  <= sl_vel_reg;
            pr_side_reg <= sl_side_reg;
            pr_g_reg    <= sl_g_reg;
            pr_lz_reg   <= sl_lz_reg;
            pr_neg_reg  <= sl_neg_reg;
            pr_num_reg  <= {mm[PROD_W-2:0], 1'b0};
            pr_den_reg  <= {1'b0, sl_ma_reg} + {1'b0, sl_mb_reg};
        end
    end

    // ---- harmonic mean divider
    logic                 lb_vld, lb_ovf;
    logic [LIM_Q_W-1:0]   lb_q;
    logic [DB_SIDE_W-1:0] lb_side;

    fskv_div #(
        .NUM_W (LIM_NUM_W),
        .DEN_W (LIM_DEN_W),
        .Q_W   (LIM_Q_W),
        .SIDE_W(DB_SIDE_W)
    ) u_div_lim (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (pr_vld_reg),
        .num      (pr_num_reg),
        .den      (pr_den_reg),
        .side_in  ({pr_side_reg, pr_mode_reg, pr_vel_reg, pr_g_reg, pr_lz_reg, pr_neg_reg}),
        .out_valid(lb_vld),
        .quot     (lb_q),
        .ovf      (lb_ovf),
        .side_out (lb_side)
    );

    // ---- gradient select
    logic [SIDE_W-1:0] lb_s_side;
    logic [1:0]        lb_s_mode_bits;
    grad_mode_t        lb_s_mode;
    logic [VAL_W-1:0]  lb_s_vel, lb_s_g, lim_g;
    logic              lb_s_lz, lb_s_neg;

    assign {lb_s_side, lb_s_mode_bits, lb_s_vel, lb_s_g, lb_s_lz, lb_s_neg} = lb_side;
    assign lb_s_mode = grad_mode_t'(lb_s_mode_bits);

    // the quotient never exceeds the larger slope, so ovf stays low
    always_comb
    begin
        if (lb_s_lz || lb_ovf)
            lim_g = '0;
        else if (lb_s_neg)
            lim_g = ~lb_q + 1'b1;
        else
            lim_g = lb_q;
    end

    logic                    gs_vld_reg;
    logic signed [VAL_W-1:0] gs_vel_reg, gs_g_reg;
    logic [SIDE_W-1:0]       gs_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gs_vld_reg <= 1'b0;
        else if (en)
            gs_vld_reg <= lb_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gs_vel_reg  <= lb_s_vel;
            gs_side_reg <= lb_s_side;
            gs_g_reg    <= (lb_s_mode == GM_LIMITED) ? lim_g : lb_s_g;
        end
    end

    // ---- velocity times gradient
    logic                     mp_vld_reg;
    logic signed [PROD_W-1:0] mp_prod_reg;
    logic [SIDE_W-1:0]        mp_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mp_vld_reg <= 1'b0;
        else if (en)
            mp_vld_reg <= gs_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp_prod_reg <= gs_vel_reg * gs_g_reg;
            mp_side_reg <= gs_side_reg;
        end
    end

    // ---- drop the fraction, truncating toward zero
    logic signed [PROD_W-1:0] biased;
    logic                     tm_vld_reg;
    logic signed [TERM_W-1:0] tm_term_reg;
    logic [SIDE_W-1:0]        tm_side_reg;

    assign biased = mp_prod_reg +
                    (mp_prod_reg[PROD_W-1] ? PROD_W'({FRAC_W{1'b1}}) : PROD_W'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tm_vld_reg <= 1'b0;
        else if (en)
            tm_vld_reg <= mp_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_term_reg <= biased[PROD_W-1:FRAC_W];
            tm_side_reg <= mp_side_reg;
        end
    end

    assign out_valid = tm_vld_reg;
    assign term      = tm_term_reg;
    assign side_out  = tm_side_reg;

endmodule

// File: src/fskv_checker.sv
// Port-level checks of the kinematic velocity core's output and skid behavior, with its bind.
// Depends on fskv_pkg and free_surface_kinematic_velocity_core.
module fskv_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [fskv_pkg::VAL_W-1:0]   w_vel
);
    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(w_vel))
        else $error("stalled output word changed");

    // input stall only while a result waits
    a_stall_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no waiting result");

    // input stall rises only after a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall raised without output stall");

    // skid drains as soon as the output moves
    a_stall_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("input stall held after output moved");

endmodule

bind free_surface_kinematic_velocity_core fskv_checker u_fskv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .w_vel    (w_vel)
);
